// File: hw/rtl/dcct_pkg.sv
`default_nettype none

package dcct_pkg;

	// scene codes
	localparam logic [1:0] SCENE_FIELD  = 2'd0;
	localparam logic [1:0] SCENE_BATTLE = 2'd1;
	localparam logic [1:0] SCENE_WORLD  = 2'd2;
	localparam logic [1:0] SCENE_OTHER  = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_MINUTE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATTLE_MULTIPLIER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMMON_MULTIPLIER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_MINUTES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MORNING_RGB       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDAY_RGB        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AFTERNOON_RGB     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_RGB         = 3'd7;

	// field and register widths
	localparam int unsigned CFG_DATA_W = 55;
	localparam int unsigned FPM_W      = 8;
	localparam int unsigned MULT_W     = 4;
	localparam int unsigned SEG_W      = 11;
	localparam int unsigned SEG_COUNT  = 5;
	localparam int unsigned RGB_W      = 24;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned CAL_W      = 8;
	localparam int unsigned FRAME_W    = 12;
	localparam int unsigned TIME_W     = 23;  // minute-of-day times frames, < 1440 * 4095
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 64;

	// calendar limits
	localparam logic [CAL_W-1:0] MINUTES_PER_HOUR = 8'd60;
	localparam logic [CAL_W-1:0] HOURS_PER_DAY    = 8'd24;
	localparam logic [CAL_W-1:0] DAY_WRAP         = 8'd32;
	localparam logic [CAL_W-1:0] MONTHS_PER_YEAR  = 8'd12;
	localparam logic [FRAME_W-1:0] FRAMES_MAX     = 12'd4095;

	// register reset values
	localparam logic [FPM_W-1:0]      FPM_RESET  = 8'd15;
	localparam logic [MULT_W-1:0]     MULT_RESET = 4'd1;
	localparam logic [CFG_DATA_W-1:0] SEG_RESET  = 55'd21120419554468200;
	localparam logic [RGB_W-1:0]      RGB_RESET  = 24'hFFFFFF;

	localparam int unsigned FRACTION_BITS_DEFAULT = 16;

endpackage

`default_nettype wire

// File: hw/rtl/day_clock_color_tint.sv
`default_nettype none

// Day clock with time-of-day color tint. Each input transfer is one video
// frame tick; each one yields exactly one output transfer carrying the enable
// flags, the blended RGB tint and the minute/hour/day/month calendar after
// the tick. Work on a tick is done by a small sequencer around one shared
// multiplier (12 x max(12, FRACTION_BITS) bits) plus a restoring divider that
// retires one quotient bit per cycle. A tick that leaves the clock idle goes
// straight to the output register; a tick that advances without tint also
// derives F and updates the calendar; a full tint tick adds the time product,
// up to five boundary multiplies, the divider loop and a blend per channel.
// s_tready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next tick can be taken before it is drained.
// Configuration writes must happen while no tick is in flight.
module day_clock_color_tint
	import dcct_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT  // 8..24
) (
	input  wire                   clk,
	input  wire                   arst_n,

	input  wire                   s_tvalid,
	output logic                  s_tready,
	// [1:0] scene_mode, [2] clock_enable, [3] advance_enable, [4] tint_enable
	input  wire  [IN_TDATA_W-1:0] s_tdata,

	output logic                   m_tvalid,
	input  wire                    m_tready,
	// [0] clock_active, [1] tint_active, [9:2] tint_red, [17:10] tint_green,
	// [25:18] tint_blue, [33:26] minute_now, [41:34] hour_now,
	// [49:42] day_now, [57:50] month_now
	output logic [OUT_TDATA_W-1:0] m_tdata,

	input  wire                    cfg_we,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data
);

	// shared multiplier geometry
	localparam int unsigned MUL_A_W   = FRAME_W;
	localparam int unsigned MUL_B_W   = (FRACTION_BITS > FRAME_W) ? FRACTION_BITS : FRAME_W;
	localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int unsigned BLEND_P_W = CHAN_W + FRACTION_BITS;
	localparam int unsigned DIV_CNT_W = $clog2(FRACTION_BITS);
	localparam logic [BLEND_P_W:0] ROUND_UP = (BLEND_P_W+1)'((1 << FRACTION_BITS) - 1);

	localparam logic [2:0] SEG_LAST = 3'(SEG_COUNT - 1);

	// channel select for the blend loop
	localparam logic [1:0] CH_R = 2'd0;
	localparam logic [1:0] CH_G = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FMUL,   // effective frames per minute
		ST_CAL,    // calendar update
		ST_TMUL,   // minute-of-day times F
		ST_TADD,   // plus frame counter
		ST_BMUL,   // boundary times F
		ST_BCMP,   // segment search
		ST_DIV,    // fraction, one bit per cycle
		ST_BLMUL,  // channel delta times fraction
		ST_BLACC,  // floored blend result
		ST_OUT
	} state_t;

	// configuration
	logic [FPM_W-1:0]      fpm_q;
	logic [MULT_W-1:0]     battle_mult_q;
	logic [MULT_W-1:0]     common_mult_q;
	logic [CFG_DATA_W-1:0] seg_minutes_q;
	logic [RGB_W-1:0]      morning_q;
	logic [RGB_W-1:0]      midday_q;
	logic [RGB_W-1:0]      afternoon_q;
	logic [RGB_W-1:0]      night_q;

	// calendar state
	logic [FRAME_W-1:0] frame_counter_q;
	logic [CAL_W-1:0]   minute_q;
	logic [CAL_W-1:0]   hour_q;
	logic [CAL_W-1:0]   day_q;
	logic [CAL_W-1:0]   month_q;

	// per-tick working registers
	state_t                   state_q;
	logic [1:0]               mode_q;
	logic                     adv_q;
	logic                     tint_q;
	logic [FRAME_W-1:0]       f_q;
	logic [TIME_W-1:0]        tm_q;
	logic [TIME_W-1:0]        bnd_q;
	logic [TIME_W-1:0]        prev_bnd_q;
	logic [2:0]               seg_idx_q;
	logic [1:0]               seg_q;
	logic [TIME_W-1:0]        span_q;
	logic [TIME_W:0]          rem_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic [1:0]               ch_q;
	logic [BLEND_P_W-1:0]     prod_q;
	logic                     active_q;
	logic [CHAN_W-1:0]        red_q;
	logic [CHAN_W-1:0]        green_q;
	logic [CHAN_W-1:0]        blue_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// combinational
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [12:0]        f_raw;
	logic [FRAME_W-1:0] f_clamped;
	logic [4:0]         mult_sel;
	logic [SEG_W-1:0]   minute_of_day;
	logic [SEG_W-1:0]   seg_bound;

	logic [FRAME_W:0]   cal_fc;
	logic [CAL_W-1:0]   cal_min;
	logic [CAL_W-1:0]   cal_hour;
	logic [CAL_W-1:0]   cal_day;
	logic [CAL_W-1:0]   cal_month;

	logic [RGB_W-1:0]  c0_rgb;
	logic [RGB_W-1:0]  c1_rgb;
	logic [CHAN_W-1:0] c0_ch;
	logic [CHAN_W-1:0] c1_ch;
	logic [CHAN_W-1:0] ch_delta;
	logic              ch_rising;
	logic [BLEND_P_W:0] down_sum;
	logic [CHAN_W-1:0] blend_res;

	logic [TIME_W:0]   rem_sh;
	logic              rem_ge;

	// result register free (or draining this cycle) while a result waits
	logic              out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpm_q         <= FPM_RESET;
			battle_mult_q <= MULT_RESET;
			common_mult_q <= MULT_RESET;
			seg_minutes_q <= SEG_RESET;
			morning_q     <= RGB_RESET;
			midday_q      <= RGB_RESET;
			afternoon_q   <= RGB_RESET;
			night_q       <= RGB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAMES_PER_MINUTE: fpm_q         <= cfg_data[FPM_W-1:0];
				REG_BATTLE_MULTIPLIER: battle_mult_q <= cfg_data[MULT_W-1:0];
				REG_COMMON_MULTIPLIER: common_mult_q <= cfg_data[MULT_W-1:0];
				REG_SEGMENT_MINUTES:   seg_minutes_q <= cfg_data;
				REG_MORNING_RGB:       morning_q     <= cfg_data[RGB_W-1:0];
				REG_MIDDAY_RGB:        midday_q      <= cfg_data[RGB_W-1:0];
				REG_AFTERNOON_RGB:     afternoon_q   <= cfg_data[RGB_W-1:0];
				REG_NIGHT_RGB:         night_q       <= cfg_data[RGB_W-1:0];
				default: ;
			endcase
		end
	end

	// battle uses its own multiplier, other scenes twice the common one
	assign mult_sel = (mode_q == SCENE_BATTLE) ? {1'b0, battle_mult_q} : {common_mult_q, 1'b0};

	// h*60 + m, calendar already normalized so it fits 11 bits
	assign minute_of_day = SEG_W'({hour_q, 6'b0}) - SEG_W'({hour_q, 2'b0}) + SEG_W'(minute_q);

	assign seg_bound = seg_minutes_q[SEG_W*seg_idx_q +: SEG_W];

	// segment colors and current channel
	always_comb begin
		case (seg_q)
			2'd0: begin
				c0_rgb = night_q;
				c1_rgb = morning_q;
			end
			2'd1: begin
				c0_rgb = morning_q;
				c1_rgb = midday_q;
			end
			2'd2: begin
				c0_rgb = midday_q;
				c1_rgb = afternoon_q;
			end
			default: begin
				c0_rgb = afternoon_q;
				c1_rgb = night_q;
			end
		endcase
		case (ch_q)
			CH_R: begin
				c0_ch = c0_rgb[23:16];
				c1_ch = c1_rgb[23:16];
			end
			CH_G: begin
				c0_ch = c0_rgb[15:8];
				c1_ch = c1_rgb[15:8];
			end
			default: begin
				c0_ch = c0_rgb[7:0];
				c1_ch = c1_rgb[7:0];
			end
		endcase
		ch_rising = (c1_ch >= c0_ch);
		ch_delta  = ch_rising ? (c1_ch - c0_ch) : (c0_ch - c1_ch);
		// falling channel rounds the step up so the result stays floored
		down_sum  = {1'b0, prod_q} + ROUND_UP;
		blend_res = ch_rising ? (c0_ch + prod_q[FRACTION_BITS +: CHAN_W])
		                      : (c0_ch - down_sum[FRACTION_BITS +: CHAN_W]);
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_FMUL: begin
				mul_a = MUL_A_W'(fpm_q);
				mul_b = MUL_B_W'(mult_sel);
			end
			ST_TMUL: begin
				mul_a = f_q;
				mul_b = MUL_B_W'(minute_of_day);
			end
			ST_BMUL: begin
				mul_a = f_q;
				mul_b = MUL_B_W'(seg_bound);
			end
			ST_BLMUL: begin
				mul_a = MUL_A_W'(ch_delta);
				mul_b = MUL_B_W'(frac_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	// F clamped to 1..4095; product is at most 255 * 30
	assign f_raw     = mul_p[12:0];
	assign f_clamped = (f_raw == '0) ? FRAME_W'(1) :
	                   (f_raw > 13'(FRAMES_MAX)) ? FRAMES_MAX : f_raw[FRAME_W-1:0];

	// calendar roll-over chain
	always_comb begin
		cal_fc    = {1'b0, frame_counter_q} + (FRAME_W+1)'(adv_q);
		cal_min   = minute_q;
		cal_hour  = hour_q;
		cal_day   = day_q;
		cal_month = month_q;
		if (cal_fc >= {1'b0, f_q}) begin
			cal_min = cal_min + 8'd1;
			cal_fc  = '0;
		end
		if (cal_min >= MINUTES_PER_HOUR) begin
			cal_hour = cal_hour + 8'd1;
			cal_min  = '0;
			cal_fc   = '0;
		end
		if (cal_hour >= HOURS_PER_DAY) begin
			cal_day  = cal_day + 8'd1;
			cal_hour = '0;
		end
		if (cal_day >= DAY_WRAP) begin
			cal_month = cal_month + 8'd1;
			cal_day   = 8'd1;
		end
		if (cal_month >= MONTHS_PER_YEAR) begin
			cal_month = '0;
		end
	end

	// restoring divider step
	assign rem_sh = {rem_q[TIME_W-1:0], 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, span_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			frame_counter_q <= '0;
			minute_q        <= '0;
			hour_q          <= '0;
			day_q           <= 8'd1;
			month_q         <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (out_load) begin
				m_tdata_q  <= {6'b0, month_q, day_q, hour_q, minute_q,
				               blue_q, green_q, red_q, active_q, active_q};
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q   <= s_tdata[1:0];
						adv_q    <= s_tdata[3];
						tint_q   <= s_tdata[4];
						active_q <= 1'b0;
						red_q    <= '0;
						green_q  <= '0;
						blue_q   <= '0;
						if (s_tdata[2] && (s_tdata[1:0] != SCENE_OTHER)) begin
							state_q <= ST_FMUL;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_FMUL: begin
					f_q     <= f_clamped;
					state_q <= ST_CAL;
				end
				ST_CAL: begin
					frame_counter_q <= cal_fc[FRAME_W-1:0];
					minute_q        <= cal_min;
					hour_q          <= cal_hour;
					day_q           <= cal_day;
					month_q         <= cal_month;
					if ((mode_q == SCENE_WORLD) || tint_q) begin
						state_q <= ST_TMUL;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_TMUL: begin
					tm_q    <= mul_p[TIME_W-1:0];
					state_q <= ST_TADD;
				end
				ST_TADD: begin
					tm_q      <= tm_q + TIME_W'(frame_counter_q);
					seg_idx_q <= '0;
					bnd_q     <= '0;
					active_q  <= 1'b1;
					// night color unless a segment claims the time
					red_q     <= night_q[23:16];
					green_q   <= night_q[15:8];
					blue_q    <= night_q[7:0];
					state_q   <= ST_BMUL;
				end
				ST_BMUL: begin
					bnd_q      <= mul_p[TIME_W-1:0];
					prev_bnd_q <= bnd_q;
					state_q    <= ST_BCMP;
				end
				ST_BCMP: begin
					if (tm_q < bnd_q) begin
						if (seg_idx_q == '0) begin
							state_q <= ST_OUT;  // before sunrise
						end else begin
							seg_q     <= 2'(seg_idx_q - 3'd1);
							span_q    <= bnd_q - prev_bnd_q;
							rem_q     <= {1'b0, tm_q - prev_bnd_q};
							div_cnt_q <= DIV_CNT_W'(FRACTION_BITS - 1);
							state_q   <= ST_DIV;
						end
					end else if (seg_idx_q == SEG_LAST) begin
						state_q <= ST_OUT;  // at or after night
					end else begin
						seg_idx_q <= seg_idx_q + 3'd1;
						state_q   <= ST_BMUL;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_ge ? (rem_sh - {1'b0, span_q}) : rem_sh;
					frac_q <= {frac_q[FRACTION_BITS-2:0], rem_ge};
					if (div_cnt_q == '0) begin
						ch_q    <= CH_R;
						state_q <= ST_BLMUL;
					end else begin
						div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					end
				end
				ST_BLMUL: begin
					prod_q  <= mul_p[BLEND_P_W-1:0];
					state_q <= ST_BLACC;
				end
				ST_BLACC: begin
					case (ch_q)
						CH_R:    red_q   <= blend_res;
						CH_G:    green_q <= blend_res;
						default: blue_q  <= blend_res;
					endcase
					if (ch_q == CH_B) begin
						state_q <= ST_OUT;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_BLMUL;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dcct_pkg::*;

	localparam int unsigned FRAC_BITS = FRACTION_BITS_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned SWEEP_PHASES = 7;
	localparam int unsigned SWEEP_TICKS = 240;
	localparam int unsigned COARSE_TICKS = 40;
	localparam int unsigned MAX_REPORTS = 10;

	// one frame tick as it travels on s_tdata
	typedef struct packed {
		logic       tint_en;
		logic       adv_en;
		logic       clk_en;
		logic [1:0] mode;
	} frame_tick_t;

	// one result as it travels on m_tdata
	typedef struct packed {
		logic              clock_active;
		logic              tint_active;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CAL_W-1:0]  minute;
		logic [CAL_W-1:0]  hour;
		logic [CAL_W-1:0]  day;
		logic [CAL_W-1:0]  month;
	} tint_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	day_clock_color_tint #(
		.FRACTION_BITS(FRAC_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the register file and of the calendar
	// ------------------------------------------------------------------
	logic [FPM_W-1:0]      fpm_cfg = FPM_RESET;
	logic [MULT_W-1:0]     battle_mul_cfg = MULT_RESET;
	logic [MULT_W-1:0]     common_mul_cfg = MULT_RESET;
	logic [CFG_DATA_W-1:0] bound_cfg = SEG_RESET;
	// morning, midday, afternoon, night
	logic [RGB_W-1:0]      color_cfg [4] = '{RGB_RESET, RGB_RESET, RGB_RESET, RGB_RESET};

	logic [FRAME_W-1:0] frame_cnt = '0;
	logic [CAL_W-1:0]   minute_cnt = '0;
	logic [CAL_W-1:0]   hour_cnt = '0;
	logic [CAL_W-1:0]   day_cnt = 8'd1;
	logic [CAL_W-1:0]   month_cnt = '0;

	frame_tick_t  frame_tick_q [$];   // ticks waiting to be offered
	tint_result_t tint_expect_q [$];  // predicted results, oldest first

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_pct = 0;         // per-phase chance of a source gap
	int unsigned stall_pct = 0;       // per-phase chance of a sink stall
	bit          no_idle = 1'b0;      // final stretch runs at full rate

	// Floored blend of one channel; the falling side rounds its step up.
	function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b, input longint unsigned frac);
		longint unsigned one;
		one = 64'd1 << FRAC_BITS;
		if (b >= a)
			return a + CHAN_W'((64'(b - a) * frac) >> FRAC_BITS);
		return a - CHAN_W'((64'(a - b) * frac + one - 64'd1) >> FRAC_BITS);
	endfunction

	// Advances the shadow calendar by one tick and returns what the block
	// should report for it.
	function automatic tint_result_t advance_day_clock(input frame_tick_t tk);
		int unsigned     fpm_eff;
		int unsigned     fc;
		longint unsigned now_frames;
		longint unsigned span;
		longint unsigned frac;
		longint unsigned bound [SEG_COUNT];
		logic [RGB_W-1:0] from_rgb;
		logic [RGB_W-1:0] color;
		bit              active;
		bit              done;
		tint_result_t    r;

		color = '0;
		active = 1'b0;
		if (tk.clk_en && tk.mode != SCENE_OTHER) begin
			fpm_eff = 32'(fpm_cfg) * ((tk.mode == SCENE_BATTLE) ?
				32'(battle_mul_cfg) : 32'(common_mul_cfg) * 32'd2);
			if (fpm_eff < 1)
				fpm_eff = 1;
			if (fpm_eff > 32'(FRAMES_MAX))
				fpm_eff = 32'(FRAMES_MAX);

			// a counter left above a lowered F still counts a minute
			fc = 32'(frame_cnt) + (tk.adv_en ? 32'd1 : 32'd0);
			if (fc >= fpm_eff) begin
				minute_cnt = minute_cnt + 8'd1;
				fc = 0;
			end
			if (minute_cnt >= MINUTES_PER_HOUR) begin
				hour_cnt = hour_cnt + 8'd1;
				minute_cnt = '0;
				fc = 0;
			end
			if (hour_cnt >= HOURS_PER_DAY) begin
				day_cnt = day_cnt + 8'd1;
				hour_cnt = '0;
			end
			if (day_cnt >= DAY_WRAP) begin
				month_cnt = month_cnt + 8'd1;
				day_cnt = 8'd1;
			end
			if (month_cnt >= MONTHS_PER_YEAR)
				month_cnt = '0;
			frame_cnt = fc[FRAME_W-1:0];

			// tint blocked in field/battle unless its enable is set
			if (tk.mode == SCENE_WORLD || tk.tint_en) begin
				now_frames = (64'(hour_cnt) * 64'd60 + 64'(minute_cnt)) * 64'(fpm_eff)
					+ 64'(frame_cnt);
				for (int i = 0; i < SEG_COUNT; i++)
					bound[i] = 64'(bound_cfg[i*SEG_W +: SEG_W]) * 64'(fpm_eff);
				// before sunrise, or at or past every later boundary: night
				color = color_cfg[3];
				done = now_frames < bound[0];
				for (int i = 0; i < 4; i++) begin
					if (!done && now_frames < bound[i+1]) begin
						span = bound[i+1] - bound[i];
						frac = ((now_frames - bound[i]) << FRAC_BITS) / span;
						from_rgb = (i == 0) ? color_cfg[3] : color_cfg[i-1];
						for (int ch = 0; ch < 3; ch++)
							color[ch*CHAN_W +: CHAN_W] = mix_channel(
								from_rgb[ch*CHAN_W +: CHAN_W],
								color_cfg[i][ch*CHAN_W +: CHAN_W], frac);
						done = 1'b1;
					end
				end
				active = 1'b1;
			end
		end

		r.clock_active = active;
		r.tint_active = active;
		r.red = color[23:16];
		r.green = color[15:8];
		r.blue = color[7:0];
		r.minute = minute_cnt;
		r.hour = hour_cnt;
		r.day = day_cnt;
		r.month = month_cnt;
		return r;
	endfunction

	function automatic string fmt_result(input tint_result_t r);
		return $sformatf("clk=%0b tint=%0b rgb=%02h_%02h_%02h %0d:%02d day %0d month %0d",
			r.clock_active, r.tint_active, r.red, r.green, r.blue,
			r.hour, r.minute, r.day, r.month);
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Source side: offers queued ticks, predicts on each transfer
	// ------------------------------------------------------------------
	frame_tick_t cur_tick;
	bit          tick_taken = 1'b0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			tint_expect_q.push_back(advance_day_clock(cur_tick));
			tick_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || tick_taken)) begin
			tick_taken = 1'b0;
			if (gap_left > 0 && !no_idle) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (!no_idle && frame_tick_q.size() > 0
					&& $urandom_range(99) < gap_pct) begin
				gap_left = $urandom_range(16, 0);
				s_tvalid <= 1'b0;
			end else if (frame_tick_q.size() > 0) begin
				cur_tick = frame_tick_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, cur_tick.tint_en, cur_tick.adv_en, cur_tick.clk_en,
					cur_tick.mode};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sink side: random backpressure, checks every result transfer
	// ------------------------------------------------------------------
	int unsigned stall_left = 0;

	always @(negedge clk) begin
		if (stall_left > 0 && !no_idle) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(16, 0);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tint_result_t got;
		tint_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			// [0] clock_active, [1] tint_active, [9:2] R, [17:10] G, [25:18] B,
			// [33:26] minute, [41:34] hour, [49:42] day, [57:50] month
			got.clock_active = m_tdata[0];
			got.tint_active = m_tdata[1];
			got.red = m_tdata[9:2];
			got.green = m_tdata[17:10];
			got.blue = m_tdata[25:18];
			got.minute = m_tdata[33:26];
			got.hour = m_tdata[41:34];
			got.day = m_tdata[49:42];
			got.month = m_tdata[57:50];
			if (tint_expect_q.size() == 0) begin
				note_failure({"result with no tick pending: ", fmt_result(got)});
			end else begin
				want = tint_expect_q.pop_front();
				if (got.clock_active !== want.clock_active
						|| got.tint_active !== want.tint_active
						|| got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue || got.minute !== want.minute
						|| got.hour !== want.hour || got.day !== want.day
						|| got.month !== want.month)
					note_failure({"expected ", fmt_result(want), " got ", fmt_result(got)});
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAMES_PER_MINUTE: fpm_cfg = val[FPM_W-1:0];
			REG_BATTLE_MULTIPLIER: battle_mul_cfg = val[MULT_W-1:0];
			REG_COMMON_MULTIPLIER: common_mul_cfg = val[MULT_W-1:0];
			REG_SEGMENT_MINUTES:   bound_cfg = val;
			REG_MORNING_RGB:       color_cfg[0] = val[RGB_W-1:0];
			REG_MIDDAY_RGB:        color_cfg[1] = val[RGB_W-1:0];
			REG_AFTERNOON_RGB:     color_cfg[2] = val[RGB_W-1:0];
			REG_NIGHT_RGB:         color_cfg[3] = val[RGB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_tick(input logic [1:0] mode, input logic c, input logic a,
			input logic t);
		frame_tick_t tk;
		tk.mode = mode;
		tk.clk_en = c;
		tk.adv_en = a;
		tk.tint_en = t;
		frame_tick_q.push_back(tk);
	endtask

	// Mostly counting ticks in an active scene; the rest is raw noise.
	task automatic queue_ticks(input int unsigned n);
		for (int unsigned k = 0; k < n; k++) begin
			if ($urandom_range(99) < 90)
				push_tick(2'($urandom_range(2, 0)), 1'b1, 1'b1, 1'($urandom));
			else
				push_tick(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	// Returns once every queued tick has been answered and the block is idle.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (frame_tick_q.size() != 0 || s_tvalid || tint_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [RGB_W-1:0] pick_color();
		case ($urandom_range(9))
			0: return '0;
			1: return RGB_RESET;
			default: return RGB_W'($urandom);
		endcase
	endfunction

	// Full register rewrite with random contents; junk above each field.
	task automatic pick_setting(input int unsigned fpm_lo, input int unsigned fpm_hi);
		int unsigned            bq [$];
		logic [CFG_DATA_W-1:0]  seg;
		logic [CFG_DATA_W-1:0]  junk;
		int unsigned            top;

		junk = {23'($urandom), 32'($urandom)};
		write_reg(REG_FRAMES_PER_MINUTE,
			{junk[CFG_DATA_W-1:FPM_W], FPM_W'($urandom_range(fpm_hi, fpm_lo))});
		write_reg(REG_BATTLE_MULTIPLIER, {junk[CFG_DATA_W-1:MULT_W], MULT_W'($urandom)});
		write_reg(REG_COMMON_MULTIPLIER, {junk[CFG_DATA_W-1:MULT_W], MULT_W'($urandom)});

		if ($urandom_range(3) == 0) begin
			// any order, boundaries may fall out of sequence
			seg = {23'($urandom), 32'($urandom)};
		end else begin
			top = ($urandom_range(3) == 0) ? 2047 : 1439;
			for (int i = 0; i < SEG_COUNT; i++)
				bq.push_back($urandom_range(top));
			bq.sort();
			seg = '0;
			for (int i = 0; i < SEG_COUNT; i++)
				seg[i*SEG_W +: SEG_W] = SEG_W'(bq[i]);
		end
		write_reg(REG_SEGMENT_MINUTES, seg);

		write_reg(REG_MORNING_RGB, {junk[CFG_DATA_W-1:RGB_W], pick_color()});
		write_reg(REG_MIDDAY_RGB, {junk[CFG_DATA_W-1:RGB_W], pick_color()});
		write_reg(REG_AFTERNOON_RGB, {junk[CFG_DATA_W-1:RGB_W], pick_color()});
		write_reg(REG_NIGHT_RGB, {junk[CFG_DATA_W-1:RGB_W], pick_color()});

		gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(25, 3);
		stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(25, 3);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset registers: every scene with the enable mixes,
		// plus a disabled clock and the inactive scene.
		gap_pct = 10;
		stall_pct = 10;
		for (int m = 0; m < 4; m++) begin
			push_tick(2'(m), 1'b1, 1'b1, 1'b1);
			push_tick(2'(m), 1'b1, 1'b1, 1'b0);   // tint blocked in field/battle
			push_tick(2'(m), 1'b1, 1'b0, 1'b1);
		end
		push_tick(SCENE_FIELD, 1'b0, 1'b1, 1'b1);
		push_tick(SCENE_WORLD, 1'b0, 1'b1, 1'b1);
		wait_idle();

		// Largest F, clamped at 4095; boundaries all ones so it is always
		// before sunrise; colors at both extremes.
		write_reg(REG_FRAMES_PER_MINUTE, CFG_DATA_W'(8'hFF));
		write_reg(REG_BATTLE_MULTIPLIER, CFG_DATA_W'(4'hF));
		write_reg(REG_COMMON_MULTIPLIER, CFG_DATA_W'(4'hF));
		write_reg(REG_SEGMENT_MINUTES, '1);
		write_reg(REG_MORNING_RGB, '0);
		write_reg(REG_MIDDAY_RGB, CFG_DATA_W'(RGB_RESET));
		write_reg(REG_AFTERNOON_RGB, '0);
		write_reg(REG_NIGHT_RGB, CFG_DATA_W'(RGB_RESET));
		push_tick(SCENE_FIELD, 1'b1, 1'b1, 1'b1);
		push_tick(SCENE_FIELD, 1'b1, 1'b1, 1'b1);
		push_tick(SCENE_BATTLE, 1'b1, 1'b1, 1'b1);
		push_tick(SCENE_WORLD, 1'b1, 1'b1, 1'b0);
		wait_idle();

		// Zero registers: F falls to 1, the stale counter forces a minute even
		// without advance, all boundaries zero so the time falls to night.
		write_reg(REG_FRAMES_PER_MINUTE, '0);
		write_reg(REG_BATTLE_MULTIPLIER, '0);
		write_reg(REG_COMMON_MULTIPLIER, '0);
		write_reg(REG_SEGMENT_MINUTES, '0);
		push_tick(SCENE_FIELD, 1'b1, 1'b0, 1'b1);
		push_tick(SCENE_BATTLE, 1'b1, 1'b0, 1'b1);
		push_tick(SCENE_WORLD, 1'b1, 1'b1, 1'b1);
		wait_idle();

		// Coarse clock with a large F, then a small one so the counter sits
		// above the new F.
		pick_setting(100, 255);
		queue_ticks(COARSE_TICKS);
		wait_idle();
		pick_setting(1, 20);
		queue_ticks(COARSE_TICKS);
		wait_idle();

		// F = 1 sweeps: one minute per counted tick, so the run walks
		// through every day segment and past midnight.
		for (int unsigned p = 0; p < SWEEP_PHASES; p++) begin
			pick_setting(0, 0);
			if (p == SWEEP_PHASES - 1)
				no_idle = 1'b1;
			queue_ticks(SWEEP_TICKS);
			wait_idle();
		end

		if (tint_expect_q.size() != 0)
			note_failure($sformatf("%0d results never arrived", tint_expect_q.size()));
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/dcct_pkg.sv
hw/rtl/day_clock_color_tint.sv
tb/testbench.sv
